FILE: rtl/deq_pkg.sv
// Package for the dedup event queue: key-space sizes, command codes, sequencer
// states, configuration register indexes. No dependencies.
`default_nettype none
package deq_pkg;
  // The world and constraint fields are 4 and 8 bits wide, so every key is in range.
  localparam int unsigned WORLDS      = 16;
  localparam int unsigned CONSTRAINTS = 256;
  localparam int unsigned WW          = $clog2(WORLDS);
  localparam int unsigned CW          = $clog2(CONSTRAINTS);
  localparam int unsigned KW          = WW + CW;
  localparam int unsigned KEYS        = WORLDS * CONSTRAINTS;
  localparam int unsigned CNTW        = 11;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_DEDUP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WLIMIT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KLIMIT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POLICY = 2'd3;
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_POP = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ENQ_WR, ST_POP_RD, ST_POP_CHK, ST_OUT
  } state_e;
endpackage
`default_nettype wire

FILE: rtl/dedup_event_queue.sv
// Top level of the dedup event queue: sequencer, key ring, pending and
// key-count table, per-world counters. Depends on deq_pkg.
//
// An item is taken in the idle state. An enqueue then does the read-modify-write
// of its key table entry in ST_ENQ_WR and presents its result on the next
// cycle. A pop passes through ST_POP_RD and ST_POP_CHK for every ring entry it
// examines (ring read, then key table read of that key), and goes from
// ST_POP_RD straight to its output state when the ring runs dry without a live
// event. The result waits in an output register until it is taken, and the
// block accepts the next item in the cycle after that transfer. After reset the
// block clears its per-key table, one key per cycle over all WORLDS*CONSTRAINTS
// keys (4096), and takes no item meanwhile.
// Configuration writes are taken at all times and should be made only while
// no item is in flight.
`default_nettype none
module dedup_event_queue #(
  parameter int unsigned RING_DEPTH  = 1024
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: cmd[0], world[4:1], constraint_id[12:5], dir_mask[14:13], zero [15]
  input  wire  [15:0]      s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire              m_axis_tready,
  // tdata: ok[0], event_valid[1], out_world[5:2], out_constraint[13:6],
  // out_dirs[15:14], out_epoch[47:16], world_overflowed[48],
  // any_overflow[49], queue_empty[50], zero [55:51]
  output logic [55:0]      m_axis_tdata,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  [1:0]       cfg_index_i,
  input  wire  [10:0]      cfg_data_i
);
  import deq_pkg::*;

  localparam int unsigned RW   = $clog2(RING_DEPTH);
  localparam int unsigned RCW  = $clog2(RING_DEPTH + 1);

  // configuration
  logic dedup_q, policy_q;
  logic [10:0] wlimit_q, klimit_q;

  // input fields
  wire       in_cmd  = s_axis_tdata[0];
  wire [3:0] in_w    = s_axis_tdata[4:1];
  wire [7:0] in_c    = s_axis_tdata[12:5];
  wire [1:0] in_dirs = s_axis_tdata[14:13];

  state_e state_q, state_d;
  logic [KW-1:0] key_q, key_d, clr_q, clr_d;
  logic [WW-1:0] w_q, w_d, kworld;
  logic [1:0] dirs_q, dirs_d;
  logic [RW-1:0] head_q, head_d, tail_q, tail_d;
  logic [RCW-1:0] rcount_q, rcount_d;
  logic [CNTW-1:0] wcnt_q [WORLDS];
  logic [CNTW-1:0] wcnt_wdata;
  logic wcnt_we;
  logic [WORLDS-1:0] ovf_q, ovf_d;
  logic ovf_any_q, ovf_any_d;
  logic [KW:0] ptot_q, ptot_d;
  logic [31:0] epoch_q, epoch_d;
  logic [55:0] res_q, res_d;

  // per-key memory: {key_count, valid, mask[1:0]}
  logic [CNTW+2:0] ktab [KEYS];
  logic [KW-1:0] ktab_raddr, ktab_waddr;
  logic [CNTW+2:0] ktab_rdata, ktab_wdata;
  logic ktab_we;

  logic [KW-1:0] ring [RING_DEPTH];
  logic [KW-1:0] ring_rdata;
  logic ring_we;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dedup_q <= 1'b1; wlimit_q <= 11'd1024; klimit_q <= 11'd1; policy_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEDUP:  dedup_q  <= cfg_data_i[0];
        CFG_WLIMIT: wlimit_q <= cfg_data_i;
        CFG_KLIMIT: klimit_q <= cfg_data_i;
        CFG_POLICY: policy_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ktab_we) ktab[ktab_waddr] <= ktab_wdata;
    ktab_rdata <= ktab[ktab_raddr];
  end

  // The ring is read at the head every cycle, so the head entry is ready
  // whenever the sequencer enters ST_POP_RD.
  always_ff @(posedge clk_i) begin
    if (ring_we) ring[tail_q] <= key_q;
    ring_rdata <= ring[head_q];
  end

  assign kworld = key_q[KW-1:CW];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = res_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:   if (clr_q == KW'(KEYS - 1)) state_d = ST_IDLE;
      ST_IDLE:    if (s_axis_tvalid) state_d = (in_cmd == CMD_POP) ? ST_POP_RD : ST_ENQ_WR;
      ST_ENQ_WR:  state_d = ST_OUT;
      ST_POP_RD:  state_d = (rcount_q == '0) ? ST_OUT : ST_POP_CHK;
      ST_POP_CHK: state_d = ktab_rdata[2] ? ST_OUT : ST_POP_RD;
      ST_OUT:     if (m_axis_tready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [CNTW-1:0] kcnt;
    kcnt = ktab_rdata[CNTW+2:3];
    clr_d = clr_q; key_d = key_q; w_d = w_q; dirs_d = dirs_q;
    head_d = head_q; tail_d = tail_q; rcount_d = rcount_q;
    ovf_d = ovf_q; ovf_any_d = ovf_any_q; ptot_d = ptot_q; epoch_d = epoch_q;
    res_d = res_q;
    ktab_raddr = key_q; ktab_waddr = key_q; ktab_wdata = ktab_rdata; ktab_we = 1'b0;
    ring_we = 1'b0; wcnt_we = 1'b0; wcnt_wdata = wcnt_q[kworld];
    case (state_q)
      ST_CLEAR: begin
        ktab_waddr = clr_q; ktab_wdata = '0; ktab_we = 1'b1;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        key_d = {in_w, in_c};
        w_d = in_w; dirs_d = in_dirs;
        ktab_raddr = key_d;
        res_d = '0;
      end
      ST_ENQ_WR: begin
        res_d[0] = 1'b1;
        if (dirs_q == 2'b00) begin
          // A zero mask leaves every table untouched.
        end else if (dedup_q && ktab_rdata[2]) begin
          ktab_wdata = {ktab_rdata[CNTW+2:2], ktab_rdata[1:0] | dirs_q}; ktab_we = 1'b1;
        end else if (wcnt_q[kworld] >= wlimit_q || kcnt >= klimit_q ||
                     rcount_q >= RCW'(RING_DEPTH)) begin
          ovf_d[kworld] = 1'b1; ovf_any_d = 1'b1; res_d[0] = policy_q;
        end else begin
          ring_we = 1'b1;
          tail_d = (tail_q == RW'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          rcount_d = rcount_q + 1'b1;
          if (!ktab_rdata[2]) ptot_d = ptot_q + 1'b1;
          ktab_wdata = {kcnt + 1'b1, 1'b1, dirs_q}; ktab_we = 1'b1;
          wcnt_we = 1'b1; wcnt_wdata = wcnt_q[kworld] + 1'b1;
        end
        res_d[48] = ovf_d[w_q];
        res_d[49] = ovf_any_d;
        res_d[50] = (ptot_d == '0);
      end
      ST_POP_RD: begin
        res_d[0] = 1'b1;
        if (rcount_q != '0) begin
          key_d = ring_rdata;
          ktab_raddr = ring_rdata;
          head_d = (head_q == RW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
          rcount_d = rcount_q - 1'b1;
        end else begin
          res_d[48] = ovf_q[w_q];
          res_d[49] = ovf_any_q;
          res_d[50] = (ptot_q == '0);
        end
      end
      ST_POP_CHK: begin
        // A key without its valid bit is a stale ring copy and is skipped.
        if (ktab_rdata[2]) begin
          ktab_wdata = {(kcnt != '0) ? kcnt - 1'b1 : kcnt, 3'b000}; ktab_we = 1'b1;
          wcnt_we = 1'b1;
          wcnt_wdata = (wcnt_q[kworld] != '0) ? wcnt_q[kworld] - 1'b1 : wcnt_q[kworld];
          ptot_d = (ptot_q != '0) ? ptot_q - 1'b1 : ptot_q;
          epoch_d = epoch_q + 32'd1;
          res_d[1] = 1'b1;
          res_d[5:2] = kworld;
          res_d[13:6] = key_q[CW-1:0];
          res_d[15:14] = ktab_rdata[1:0];
          res_d[47:16] = epoch_q;
          res_d[48] = ovf_q[w_q];
          res_d[49] = ovf_any_q;
          res_d[50] = (ptot_d == '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORLDS; i++) wcnt_q[i] <= '0;
    end else if (wcnt_we) begin
      wcnt_q[kworld] <= wcnt_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; key_q <= '0; w_q <= '0; dirs_q <= '0;
      head_q <= '0; tail_q <= '0; rcount_q <= '0; ovf_q <= '0; ovf_any_q <= 1'b0;
      ptot_q <= '0; epoch_q <= '0; res_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; key_q <= key_d; w_q <= w_d; dirs_q <= dirs_d;
      head_q <= head_d; tail_q <= tail_d; rcount_q <= rcount_d; ovf_q <= ovf_d;
      ovf_any_q <= ovf_any_d; ptot_q <= ptot_d; epoch_q <= epoch_d; res_q <= res_d;
    end
  end
endmodule
`default_nettype wire

FILE: sim/tb_dedup_event_queue.sv
// Testbench for dedup_event_queue: directed and random enqueue/pop streams
// checked against an in-bench model of the pending-event queue. Uses deq_pkg.
`timescale 1ns / 100ps

module tb_dedup_event_queue;
  import deq_pkg::*;

  localparam int NWORLDS   = 16;
  localparam int NCONS     = 256;
  localparam int NKEYS     = NWORLDS * NCONS;
  localparam int RING      = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic        ok;
    logic        ev;
    logic [3:0]  world;
    logic [7:0]  cons;
    logic [1:0]  dirs;
    logic [31:0] epoch;
    logic        wof;
    logic        aof;
    logic        qe;
  } qresult_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [55:0] m_tdata;
  wire         cfg_ready;

  dedup_event_queue u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Queue model state.
  logic [11:0] ring_keys [RING];
  int          q_head, q_tail, q_count;
  bit          pend_valid [NKEYS];
  logic [1:0]  pend_mask [NKEYS];
  int          world_pending [NWORLDS];
  int          key_pending [NKEYS];
  bit          world_flag [NWORLDS];
  bit          any_flag;
  int          pend_total;
  logic [31:0] epoch_ctr;
  bit          dedup_on;
  int          world_lim, key_lim;
  bit          drop_ok;

  qresult_t    exp_fifo [EXP_DEPTH];
  int          exp_wr, exp_rd;
  int          errors, n_enq, n_pop, n_events, n_overflow, n_results, n_stale;
  int          burst_left;
  bit          no_gaps;
  int          idle_cycles;

  function automatic void exp_put(qresult_t r);
    exp_fifo[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  function automatic qresult_t exp_take();
    qresult_t r;
    r = exp_fifo[exp_rd % EXP_DEPTH];
    exp_rd++;
    return r;
  endfunction

  function automatic qresult_t queue_model_step(logic cmd, logic [3:0] w, logic [7:0] c,
                                                logic [1:0] m);
    qresult_t    r;
    logic [11:0] key;
    bit          done;
    r = '0;
    key = {w, c};
    if (cmd == CMD_ENQ) begin
      n_enq++;
      r.ok = 1'b1;
      if (m != 2'd0) begin
        if (dedup_on && pend_valid[key]) begin
          pend_mask[key] |= m;
        end else if (world_pending[w] >= world_lim || key_pending[key] >= key_lim ||
                     q_count >= RING) begin
          world_flag[w] = 1'b1;
          any_flag = 1'b1;
          r.ok = drop_ok;
          n_overflow++;
        end else begin
          ring_keys[q_tail] = key;
          q_tail = (q_tail + 1) % RING;
          q_count++;
          if (!pend_valid[key]) pend_total++;
          pend_valid[key] = 1'b1;
          pend_mask[key] = m;
          world_pending[w]++;
          key_pending[key]++;
        end
      end
    end else begin
      n_pop++;
      r.ok = 1'b1;
      done = 1'b0;
      while (q_count > 0 && !done) begin
        key = ring_keys[q_head];
        q_head = (q_head + 1) % RING;
        q_count--;
        if (!pend_valid[key]) begin
          n_stale++;
        end else begin
          done = 1'b1;
          n_events++;
          r.ev = 1'b1;
          r.world = key[11:8];
          r.cons = key[7:0];
          r.dirs = pend_mask[key];
          r.epoch = epoch_ctr;
          epoch_ctr++;
          pend_valid[key] = 1'b0;
          pend_mask[key] = 2'd0;
          if (pend_total > 0) pend_total--;
          if (world_pending[key[11:8]] > 0) world_pending[key[11:8]]--;
          if (key_pending[key] > 0) key_pending[key]--;
        end
      end
    end
    r.wof = world_flag[w];
    r.aof = any_flag;
    r.qe = (pend_total == 0);
    return r;
  endfunction

  task automatic send_item(logic cmd, logic [3:0] w, logic [7:0] c, logic [1:0] m);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, m, c, w, cmd};
    do @(posedge clk_i); while (!s_tready);
    exp_put(queue_model_step(cmd, w, c, m));
  endtask

  // Lets every expected result arrive, then gives the block time to settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    wait (exp_wr == exp_rd);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[10:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DEDUP:  dedup_on = value[0];
      CFG_WLIMIT: world_lim = int'(value[10:0]);
      CFG_KLIMIT: key_lim = int'(value[10:0]);
      CFG_POLICY: drop_ok = value[0];
      default:    ;
    endcase
  endtask

  task automatic set_config(bit dd, int wl, int kl, bit dp);
    write_reg(CFG_DEDUP, dd);
    write_reg(CFG_WLIMIT, wl);
    write_reg(CFG_KLIMIT, kl);
    write_reg(CFG_POLICY, dp);
  endtask

  task automatic pop_until_ring_empty();
    while (q_count > 0) send_item(CMD_POP, 4'($urandom), 8'($urandom), 2'($urandom));
  endtask

  // Reset settings: merges, zero masks, extremes of world and constraint.
  task automatic test_merge_basics();
    send_item(CMD_POP, 4'd0, 8'd0, 2'd0);
    send_item(CMD_ENQ, 4'd0, 8'd0, 2'd1);
    send_item(CMD_ENQ, 4'd0, 8'd0, 2'd2);
    send_item(CMD_ENQ, 4'd15, 8'd255, 2'd3);
    send_item(CMD_ENQ, 4'd15, 8'd255, 2'd0);
    send_item(CMD_ENQ, 4'd9, 8'd170, 2'd0);
    send_item(CMD_POP, 4'd15, 8'd255, 2'd3);
    send_item(CMD_POP, 4'd0, 8'd0, 2'd0);
    send_item(CMD_POP, 4'd0, 8'd0, 2'd0);
  endtask

  // With dedup off a repeated key overwrites its mask and leaves a stale copy.
  task automatic test_stale_entries();
    set_config(1'b0, 1024, 2, 1'b0);
    send_item(CMD_ENQ, 4'd2, 8'd5, 2'd1);
    send_item(CMD_ENQ, 4'd2, 8'd5, 2'd2);
    send_item(CMD_ENQ, 4'd2, 8'd5, 2'd3);
    send_item(CMD_POP, 4'd2, 8'd0, 2'd0);
    send_item(CMD_POP, 4'd2, 8'd0, 2'd0);
    send_item(CMD_ENQ, 4'd2, 8'd5, 2'd1);
    send_item(CMD_POP, 4'd2, 8'd0, 2'd0);
  endtask

  // Limits reached, under both overflow policies and the zero limits.
  task automatic test_limits();
    set_config(1'b1, 1, 1024, 1'b0);
    send_item(CMD_ENQ, 4'd3, 8'd1, 2'd1);
    send_item(CMD_ENQ, 4'd3, 8'd2, 2'd2);
    send_item(CMD_ENQ, 4'd4, 8'd2, 2'd2);
    set_config(1'b1, 1024, 0, 1'b1);
    send_item(CMD_ENQ, 4'd5, 8'd7, 2'd3);
    send_item(CMD_POP, 4'd5, 8'd0, 2'd0);
    set_config(1'b0, 0, 1, 1'b0);
    send_item(CMD_ENQ, 4'd6, 8'd7, 2'd1);
    send_item(CMD_POP, 4'd6, 8'd0, 2'd0);
  endtask

  // Fills the ring to capacity from a small key pool so the ring-full case is
  // hit, then drains it; the drain skips long runs of stale copies.
  task automatic test_ring_full();
    set_config(1'b0, 1024, 1024, 1'($urandom));
    pop_until_ring_empty();
    no_gaps = 1'b1;
    for (int i = 0; i < RING + 6; i++)
      send_item(CMD_ENQ, 4'(i), 8'($urandom_range(0, 3)), 2'($urandom_range(1, 3)));
    no_gaps = 1'b0;
    pop_until_ring_empty();
  endtask

  // Random mixes of enqueues and pops on a small key pool, under varied settings.
  task automatic test_random_mix();
    int wl_pick [5] = '{0, 1, 4, 37, 1024};
    int kl_pick [5] = '{0, 1, 2, 3, 1024};
    logic [3:0] w;
    logic [7:0] c;
    for (int ph = 0; ph < 4; ph++) begin
      set_config(1'($urandom), wl_pick[$urandom_range(0, 4)],
                 (ph == 0) ? 1 : kl_pick[$urandom_range(0, 4)], 1'($urandom));
      for (int i = 0; i < 20; i++) begin
        w = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        c = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(250, 255));
        if ($urandom_range(0, 9) < 4) send_item(CMD_POP, w, c, 2'($urandom));
        else send_item(CMD_ENQ, w, c, ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom));
      end
    end
    set_config(1'b1, 1024, 1, 1'b0);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Receiver: alternates between always-ready stretches and random stalls.
  int stall_left, mode_ctr;
  always @(posedge clk_i) begin
    mode_ctr <= mode_ctr + 1;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (mode_ctr[6] && $urandom_range(0, 2) == 0) begin
      stall_left <= $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    qresult_t want, got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tdata[0], m_tdata[1], m_tdata[5:2], m_tdata[13:6], m_tdata[15:14],
             m_tdata[47:16], m_tdata[48], m_tdata[49], m_tdata[50]};
      n_results++;
      if (exp_wr == exp_rd) begin
        $error("result transfer with no expected result: %h", m_tdata);
        errors++;
      end else begin
        want = exp_take();
        check_field("ok", 32'(want.ok), 32'(got.ok));
        check_field("event_valid", 32'(want.ev), 32'(got.ev));
        check_field("out_world", 32'(want.world), 32'(got.world));
        check_field("out_constraint", 32'(want.cons), 32'(got.cons));
        check_field("out_dirs", 32'(want.dirs), 32'(got.dirs));
        check_field("out_epoch", want.epoch, got.epoch);
        check_field("world_overflowed", 32'(want.wof), 32'(got.wof));
        check_field("any_overflow", 32'(want.aof), 32'(got.aof));
        check_field("queue_empty", 32'(want.qe), 32'(got.qe));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("** dedup_event_queue: FAILED **");
      $finish;
    end
  end

  initial begin
    q_head = 0; q_tail = 0; q_count = 0; pend_total = 0; epoch_ctr = '0; any_flag = 0;
    for (int k = 0; k < NKEYS; k++) begin
      pend_valid[k] = 0; pend_mask[k] = '0; key_pending[k] = 0;
    end
    for (int k = 0; k < NWORLDS; k++) begin
      world_pending[k] = 0; world_flag[k] = 0;
    end
    dedup_on = 1; world_lim = 1024; key_lim = 1; drop_ok = 0;
    exp_wr = 0; exp_rd = 0;
    errors = 0; n_enq = 0; n_pop = 0; n_events = 0; n_overflow = 0; n_results = 0;
    n_stale = 0; burst_left = 0; no_gaps = 0; idle_cycles = 0; stall_left = 0; mode_ctr = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_merge_basics();
    test_stale_entries();
    test_limits();
    test_random_mix();
    test_ring_full();
    drain_results();
    repeat (20) @(posedge clk_i);
    $display("covered %0d enqueues (%0d over a limit), %0d pops (%0d events, %0d stale skips)",
             n_enq, n_overflow, n_pop, n_events, n_stale);
    $display("%0d results checked under merge, overwrite, limit and ring-full settings",
             n_results);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("** dedup_event_queue: PASSED **");
    end else begin
      $display("** dedup_event_queue: FAILED **");
    end
    $finish;
  end

endmodule
